// File: sv/assembly_token_scanner_defines.svh
`ifndef ASSEMBLY_TOKEN_SCANNER_DEFINES_SVH
`define ASSEMBLY_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle check.
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check.
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ats_pkg.sv
package ats_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int NUM_KEYWORDS = 7;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_INT  = 3'd1,
    MODE_WORD = 3'd2,
    MODE_V    = 3'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_NEWLINE = 4'd0,
    KIND_COLON   = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_INT     = 4'd3,
    KIND_REG     = 4'd4,
    KIND_IDENT   = 4'd5,
    KIND_COPY    = 4'd6,
    KIND_ADD     = 4'd7,
    KIND_SUB     = 4'd8,
    KIND_AND     = 4'd9,
    KIND_OR      = 4'd10,
    KIND_XOR     = 4'd11,
    KIND_JUMP    = 4'd12,
    KIND_END     = 4'd13,
    KIND_INVALID = 4'd14
  } kind_t;

  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_V          = 8'h56;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam logic [31:0] KW_CODE [NUM_KEYWORDS] = '{
    32'h636F7079, 32'h00616464, 32'h00737562, 32'h00616E64,
    32'h00006F72, 32'h00786F72, 32'h6A756D70
  };
  localparam logic [15:0] KW_LEN [NUM_KEYWORDS] = '{
    16'd4, 16'd3, 16'd3, 16'd3, 16'd2, 16'd3, 16'd4
  };
  localparam kind_t KW_KIND [NUM_KEYWORDS] = '{
    KIND_COPY, KIND_ADD, KIND_SUB, KIND_AND, KIND_OR, KIND_XOR, KIND_JUMP
  };

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  // Up to three tokens caused by one byte.
  typedef struct packed {
    logic           valid;
    token_t [2:0]   tok;
    logic   [1:0]   cnt;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_reg(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic kind_t word_kind(input logic [31:0] prefix, input logic [15:0] count);
    kind_t k;
    k = KIND_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if ((count == KW_LEN[i]) && (prefix == KW_CODE[i])) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

// File: sv/ats_channels.sv
interface ats_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       is_final;

  modport source (output valid, source_byte, is_final, input ready);
  modport sink   (input valid, source_byte, is_final, output ready);
endinterface

interface ats_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        run_end;

  modport source (output valid, token_kind, token_start, token_length, run_end,
                  input ready);
  modport sink   (input valid, token_kind, token_start, token_length, run_end,
                  output ready);
endinterface

// File: sv/ats_scan.sv
`include "assembly_token_scanner_defines.svh"

module ats_scan #(
  parameter int OFFSET_BITS = ats_pkg::OFFSET_BITS
) (
  input  logic             clk,
  input  logic             rst,
  ats_byte_if.sink         bytes,
  output ats_pkg::bundle_t bund,
  input  logic             drain
);

  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_final;

  logic [OFFSET_BITS-1:0] byte_position;
  ats_pkg::mode_t         scan_mode;
  logic [OFFSET_BITS-1:0] token_origin;
  logic [31:0]            word_prefix;
  logic [15:0]            word_count;
  logic                   halted_by_error;

  ats_pkg::mode_t         mode_scan;
  logic [OFFSET_BITS-1:0] origin_scan;
  logic [31:0]            prefix_scan;
  logic [15:0]            count_scan;
  logic                   halted_scan;

  logic adv;
  logic dig, alp, wrd, regc, spc, nl, col, pls, single, invalid_byte, cont;
  logic [15:0] count_inc;
  logic [31:0] wadd_prefix;
  logic [15:0] pos_sat, origin_sat;

  ats_pkg::token_t [3:0] cand;
  logic [3:0]            cand_v;
  ats_pkg::token_t [2:0] slots;
  logic [2:0]            n;

  function automatic logic [15:0] sat_off(input logic [OFFSET_BITS-1:0] v);
    return (|(v >> 16)) ? 16'hFFFF : 16'(v);
  endfunction

  assign adv         = inq_valid && (!bund.valid || drain);
  assign bytes.ready = !rst && (!inq_valid || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (bytes.ready) begin
      inq_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      inq_byte  <= bytes.source_byte;
      inq_final <= bytes.is_final;
    end
  end

  assign dig          = ats_pkg::is_digit(inq_byte);
  assign alp          = ats_pkg::is_alpha(inq_byte);
  assign wrd          = ats_pkg::is_word(inq_byte);
  assign regc         = ats_pkg::is_reg(inq_byte);
  assign spc          = ats_pkg::is_space(inq_byte);
  assign nl           = inq_byte == ats_pkg::CH_NEWLINE;
  assign col          = inq_byte == ats_pkg::CH_COLON;
  assign pls          = inq_byte == ats_pkg::CH_PLUS;
  assign single       = nl || col || pls;
  assign invalid_byte = !(single || spc || dig || alp);

  // Byte extends (or completes) the pending run.
  assign cont = ((scan_mode == ats_pkg::MODE_INT) && dig) ||
                ((scan_mode == ats_pkg::MODE_WORD) && wrd) ||
                ((scan_mode == ats_pkg::MODE_V) && wrd);

  assign count_inc   = (word_count != 16'hFFFF) ? word_count + 16'd1 : word_count;
  assign wadd_prefix = (word_count < 16'd4) ? {word_prefix[23:0], inq_byte} : word_prefix;
  assign pos_sat     = sat_off(byte_position);
  assign origin_sat  = sat_off(token_origin);

  // Next scan state, before the final-byte reset
  always_comb begin
    mode_scan   = scan_mode;
    origin_scan = token_origin;
    prefix_scan = word_prefix;
    count_scan  = word_count;
    halted_scan = halted_by_error;
    if (!halted_by_error) begin
      case (scan_mode)
        ats_pkg::MODE_INT: begin
          if (dig) count_scan = count_inc;
        end
        ats_pkg::MODE_WORD: begin
          if (wrd) begin
            prefix_scan = wadd_prefix;
            count_scan  = count_inc;
          end
        end
        ats_pkg::MODE_V: begin
          if (regc) begin
            mode_scan   = ats_pkg::MODE_IDLE;
            prefix_scan = '0;
            count_scan  = '0;
          end else if (wrd) begin
            mode_scan   = ats_pkg::MODE_WORD;
            prefix_scan = wadd_prefix;
            count_scan  = count_inc;
          end
        end
        default: ;
      endcase
      if (!cont) begin
        mode_scan   = ats_pkg::MODE_IDLE;
        prefix_scan = '0;
        count_scan  = '0;
        if (single || spc) begin
        end else if (dig) begin
          mode_scan   = ats_pkg::MODE_INT;
          origin_scan = byte_position;
          count_scan  = 16'd1;
        end else if (alp) begin
          mode_scan   = (inq_byte == ats_pkg::CH_V) ? ats_pkg::MODE_V : ats_pkg::MODE_WORD;
          origin_scan = byte_position;
          prefix_scan = {24'd0, inq_byte};
          count_scan  = 16'd1;
        end else begin
          halted_scan = 1'b1;
        end
      end
    end
  end

  // Candidate tokens in emission order
  always_comb begin
    cand   = '0;
    cand_v = '0;

    // pending run closed, or register completed
    cand_v[0]        = !halted_by_error && (scan_mode != ats_pkg::MODE_IDLE) &&
                       (!cont || ((scan_mode == ats_pkg::MODE_V) && regc));
    cand[0].start    = origin_sat;
    cand[0].kind     = ats_pkg::KIND_IDENT;
    cand[0].length   = 16'd1;
    case (scan_mode)
      ats_pkg::MODE_INT: begin
        cand[0].kind   = ats_pkg::KIND_INT;
        cand[0].length = word_count;
      end
      ats_pkg::MODE_WORD: begin
        cand[0].kind   = ats_pkg::word_kind(word_prefix, word_count);
        cand[0].length = word_count;
      end
      ats_pkg::MODE_V: begin
        if (regc) begin
          cand[0].kind   = ats_pkg::KIND_REG;
          cand[0].length = 16'd2;
        end
      end
      default: ;
    endcase

    // the byte's own token
    cand_v[1]      = !halted_by_error && !cont && (single || invalid_byte);
    cand[1].start  = pos_sat;
    cand[1].length = 16'd1;
    cand[1].kind   = nl  ? ats_pkg::KIND_NEWLINE :
                     col ? ats_pkg::KIND_COLON :
                     pls ? ats_pkg::KIND_PLUS : ats_pkg::KIND_INVALID;

    // run still open at the final byte
    cand_v[2]      = inq_final && !halted_scan && (mode_scan != ats_pkg::MODE_IDLE);
    cand[2].start  = sat_off(origin_scan);
    cand[2].kind   = ats_pkg::KIND_IDENT;
    cand[2].length = 16'd1;
    case (mode_scan)
      ats_pkg::MODE_INT: begin
        cand[2].kind   = ats_pkg::KIND_INT;
        cand[2].length = count_scan;
      end
      ats_pkg::MODE_WORD: begin
        cand[2].kind   = ats_pkg::word_kind(prefix_scan, count_scan);
        cand[2].length = count_scan;
      end
      default: ;
    endcase

    cand_v[3]      = inq_final;
    cand[3].kind   = ats_pkg::KIND_END;
    cand[3].start  = pos_sat;
    cand[3].length = 16'd1;
  end

  always_comb begin
    slots = '0;
    n     = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n < 3'd3) slots[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      scan_mode       <= ats_pkg::MODE_IDLE;
      token_origin    <= '0;
      word_prefix     <= '0;
      word_count      <= '0;
      halted_by_error <= 1'b0;
    end else if (adv) begin
      if (inq_final) begin
        byte_position   <= '0;
        scan_mode       <= ats_pkg::MODE_IDLE;
        token_origin    <= '0;
        word_prefix     <= '0;
        word_count      <= '0;
        halted_by_error <= 1'b0;
      end else begin
        if (byte_position != '1) byte_position <= byte_position + 1'b1;
        scan_mode       <= mode_scan;
        token_origin    <= origin_scan;
        word_prefix     <= prefix_scan;
        word_count      <= count_scan;
        halted_by_error <= halted_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bund.valid <= 1'b0;
    end else if (adv && (n != 3'd0)) begin
      bund.valid <= 1'b1;
    end else if (drain) begin
      bund.valid <= 1'b0;
    end
    if (adv && (n != 3'd0)) begin
      bund.tok <= slots;
      bund.cnt <= n[1:0];
    end
  end

  `ATS_ASSERT_NOW(a_bundle_nonempty, bund.valid, bund.cnt != 2'd0, "empty token bundle held")
  `ATS_ASSERT_NOW(a_halt_idle, halted_by_error, scan_mode == ats_pkg::MODE_IDLE, "run open after error")
  `ATS_ASSERT_NEXT(a_final_reset, adv && inq_final, (byte_position == '0) && !halted_by_error, "state not cleared after final byte")

endmodule

// File: sv/ats_emit.sv
`include "assembly_token_scanner_defines.svh"

module ats_emit (
  input  logic             clk,
  input  logic             rst,
  input  ats_pkg::bundle_t bund,
  output logic             drain,
  ats_token_if.source      tokens
);

  logic [1:0]      idx;
  logic            last;
  ats_pkg::token_t sel;

  assign sel  = bund.tok[idx];
  assign last = idx == (bund.cnt - 2'd1);

  assign tokens.valid        = bund.valid;
  assign tokens.token_kind   = sel.kind;
  assign tokens.token_start  = sel.start;
  assign tokens.token_length = sel.length;
  assign tokens.run_end      = last;

  assign drain = tokens.valid && tokens.ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (tokens.valid && tokens.ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  `ATS_ASSERT_NOW(a_idx_in_range, bund.valid, idx < bund.cnt, "token index past bundle")
  `ATS_ASSERT_NEXT(a_idx_rewind, drain, idx == 2'd0, "index not rewound after bundle")

endmodule

// File: sv/assembly_token_scanner.sv
// Assembly token scanner. Takes one source byte per transfer on bytes and
// sends tokens (kind, start offset, length, run_end on the last token of a
// byte) on tokens. Each byte passes an input register and is scanned into a
// bundle of up to three tokens in the bundle register. The tokens leave the
// bundle one per cycle while the receiver is ready, and the next byte is not
// scanned until the bundle drains. The first token of a byte thus passes the
// input register and the bundle register before it appears. Offsets saturate
// at 2^OFFSET_BITS - 1 internally and at 65535 on the port; lengths at 65535.
module assembly_token_scanner #(
  parameter int OFFSET_BITS = ats_pkg::OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  ats_byte_if.sink    bytes,
  ats_token_if.source tokens
);

  ats_pkg::bundle_t bund;
  logic             drain;

  ats_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .bund  (bund),
    .drain (drain)
  );

  ats_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .bund   (bund),
    .drain  (drain),
    .tokens (tokens)
  );

endmodule

// File: tb/sv/testbench.sv
module testbench;

  typedef struct packed {
    ats_pkg::kind_t kind;
    logic [15:0]    start;
    logic [15:0]    length;
    logic           run_end;
  } token_exp_t;

  typedef struct {
    logic [7:0]     ch;
    bit             fin;
    bit             typed;
    ats_pkg::kind_t kind;
    logic [15:0]    start;
    logic [15:0]    length;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  ats_byte_if  byte_ch ();
  ats_token_if token_ch ();

  assembly_token_scanner i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .tokens (token_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scanner state as seen by the predictor.
  logic [15:0]    scan_pos;
  ats_pkg::mode_t scan_state;
  logic [15:0]    run_origin;
  logic [31:0]    run_prefix;
  logic [15:0]    run_count;
  bit             run_halted;

  token_exp_t  byte_tokens [$];
  token_exp_t  awaited_tokens [$];
  logic [7:0]  source_text [$];
  int          token_errors = 0;
  int          burst_left = 0;
  int          last_count;

  directed_row_t plan [25] = '{
    '{ats_pkg::CH_NEWLINE,    1'b0, 1'b1, ats_pkg::KIND_NEWLINE, 16'd0, 16'd1},
    '{ats_pkg::CH_COLON,      1'b0, 1'b1, ats_pkg::KIND_COLON,   16'd1, 16'd1},
    '{ats_pkg::CH_PLUS,       1'b0, 1'b1, ats_pkg::KIND_PLUS,    16'd2, 16'd1},
    '{" ",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{8'h09,                  1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"0",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"9",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{ats_pkg::CH_V,          1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"F",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{ats_pkg::CH_V,          1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{8'h0D,                  1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{ats_pkg::CH_V,          1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"x",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{ats_pkg::CH_UNDERSCORE, 1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"a",                    1'b1, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"o",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"r",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"$",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{"a",                    1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{8'hFF,                  1'b0, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{8'h00,                  1'b1, 1'b1, ats_pkg::KIND_END,     16'd5, 16'd1},
    '{8'h00,                  1'b0, 1'b1, ats_pkg::KIND_INVALID, 16'd0, 16'd1},
    '{"1",                    1'b1, 1'b1, ats_pkg::KIND_END,     16'd1, 16'd1},
    '{"7",                    1'b1, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0},
    '{ats_pkg::CH_V,          1'b1, 1'b0, ats_pkg::KIND_IDENT,   16'd0, 16'd0}
  };

  function automatic bit ch_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit ch_word(input logic [7:0] c);
    return ch_alpha(c) || ch_digit(c) || c == ats_pkg::CH_UNDERSCORE;
  endfunction

  function automatic bit ch_reg(input logic [7:0] c);
    return ch_digit(c) || (c >= "A" && c <= "F");
  endfunction

  function automatic bit ch_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic ats_pkg::kind_t keyword_of(input logic [31:0] pre,
                                                input logic [15:0] cnt);
    if (cnt == 16'd4 && pre == "copy") return ats_pkg::KIND_COPY;
    if (cnt == 16'd3 && pre == "add") return ats_pkg::KIND_ADD;
    if (cnt == 16'd3 && pre == "sub") return ats_pkg::KIND_SUB;
    if (cnt == 16'd3 && pre == "and") return ats_pkg::KIND_AND;
    if (cnt == 16'd2 && pre == "or") return ats_pkg::KIND_OR;
    if (cnt == 16'd3 && pre == "xor") return ats_pkg::KIND_XOR;
    if (cnt == 16'd4 && pre == "jump") return ats_pkg::KIND_JUMP;
    return ats_pkg::KIND_IDENT;
  endfunction

  function automatic void clear_scan();
    scan_pos = '0;
    scan_state = ats_pkg::MODE_IDLE;
    run_origin = '0;
    run_prefix = '0;
    run_count = '0;
    run_halted = 1'b0;
  endfunction

  function automatic void add_token(input ats_pkg::kind_t k, input logic [15:0] s,
                                    input logic [15:0] l);
    byte_tokens.push_back('{k, s, l, 1'b0});
  endfunction

  function automatic void word_push(input logic [7:0] c);
    if (run_count < 16'd4) run_prefix = {run_prefix[23:0], c};
    if (run_count != 16'hFFFF) run_count++;
  endfunction

  function automatic void close_run();
    case (scan_state)
      ats_pkg::MODE_INT: add_token(ats_pkg::KIND_INT, run_origin, run_count);
      ats_pkg::MODE_WORD: add_token(keyword_of(run_prefix, run_count), run_origin, run_count);
      ats_pkg::MODE_V: add_token(ats_pkg::KIND_IDENT, run_origin, 16'd1);
      default: ;
    endcase
    scan_state = ats_pkg::MODE_IDLE;
    run_prefix = '0;
    run_count = '0;
  endfunction

  // Works out the tokens one byte causes and queues them; returns how many.
  function automatic int scan_byte(input logic [7:0] c, input bit fin);
    logic [15:0] pos;
    bit          taken;
    pos = scan_pos;
    taken = 1'b0;
    byte_tokens.delete();
    if (!run_halted) begin
      case (scan_state)
        ats_pkg::MODE_INT: begin
          if (ch_digit(c)) begin
            if (run_count != 16'hFFFF) run_count++;
            taken = 1'b1;
          end else close_run();
        end
        ats_pkg::MODE_WORD: begin
          if (ch_word(c)) begin
            word_push(c);
            taken = 1'b1;
          end else close_run();
        end
        ats_pkg::MODE_V: begin
          if (ch_reg(c)) begin
            add_token(ats_pkg::KIND_REG, run_origin, 16'd2);
            scan_state = ats_pkg::MODE_IDLE;
            run_prefix = '0;
            run_count = '0;
            taken = 1'b1;
          end else if (ch_word(c)) begin
            scan_state = ats_pkg::MODE_WORD;
            word_push(c);
            taken = 1'b1;
          end else close_run();
        end
        default: ;
      endcase
      if (!taken) begin
        if (c == ats_pkg::CH_NEWLINE) add_token(ats_pkg::KIND_NEWLINE, pos, 16'd1);
        else if (c == ats_pkg::CH_COLON) add_token(ats_pkg::KIND_COLON, pos, 16'd1);
        else if (c == ats_pkg::CH_PLUS) add_token(ats_pkg::KIND_PLUS, pos, 16'd1);
        else if (ch_space(c)) begin
        end else if (ch_digit(c)) begin
          scan_state = ats_pkg::MODE_INT;
          run_origin = pos;
          run_count = 16'd1;
        end else if (ch_alpha(c)) begin
          scan_state = (c == ats_pkg::CH_V) ? ats_pkg::MODE_V : ats_pkg::MODE_WORD;
          run_origin = pos;
          run_prefix = '0;
          run_count = '0;
          word_push(c);
        end else begin
          add_token(ats_pkg::KIND_INVALID, pos, 16'd1);
          run_halted = 1'b1;
        end
      end
    end
    if (fin) begin
      if (!run_halted) close_run();
      add_token(ats_pkg::KIND_END, pos, 16'd1);
      clear_scan();
    end else if (scan_pos != 16'hFFFF) begin
      scan_pos++;
    end
    if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].run_end = 1'b1;
    foreach (byte_tokens[i]) awaited_tokens.push_back(byte_tokens[i]);
    return byte_tokens.size();
  endfunction

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range("a", "z"));
      2: return 8'($urandom_range("A", "Z"));
      3, 4: return 8'($urandom_range("0", "9"));
      default: return ats_pkg::CH_UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] rand_reg_char();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 9))
      0, 1, 2: return " ";
      3: return 8'h09;
      4: return 8'h0B;
      5: return 8'h0C;
      6: return 8'h0D;
      7: return ats_pkg::CH_NEWLINE;
      8: return ats_pkg::CH_COLON;
      default: return ats_pkg::CH_PLUS;
    endcase
  endfunction

  // Mostly well-formed lines of tokens, with the odd stray byte.
  function automatic void build_source();
    string keywords [7] = '{"copy", "add", "sub", "and", "or", "xor", "jump"};
    string word;
    source_text.delete();
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          word = keywords[$urandom_range(0, 6)];
          foreach (word[j]) source_text.push_back(word[j]);
        end
        5, 6, 7: begin
          source_text.push_back(rand_alpha());
          repeat ($urandom_range(0, 7)) source_text.push_back(rand_word_char());
        end
        8, 9, 10: begin
          repeat ($urandom_range(1, 5)) source_text.push_back(8'($urandom_range("0", "9")));
        end
        11, 12, 13: begin
          source_text.push_back(ats_pkg::CH_V);
          source_text.push_back(rand_reg_char());
        end
        14: source_text.push_back(ats_pkg::CH_V);
        15: begin
          source_text.push_back(ats_pkg::CH_V);
          source_text.push_back(8'($urandom_range("a", "z")));
          repeat ($urandom_range(0, 4)) source_text.push_back(rand_word_char());
        end
        16: source_text.push_back(8'($urandom_range(0, 255)));
        default: source_text.push_back(rand_separator());
      endcase
      if ($urandom_range(0, 7) != 0) source_text.push_back(rand_separator());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit fin);
    if (burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.source_byte <= b;
    byte_ch.is_final <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    burst_left--;
    last_count = scan_byte(b, fin);
  endtask

  task automatic drain_tokens();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_tokens.size() != 0);
  endtask

  // Receiver stalls: a 16-bit rotating pattern, reloaded once all its bits have been used.
  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age = 0;

  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= 16'hFFFF;
        1: stall_pattern <= 16'($urandom);
        2: stall_pattern <= 16'h01FF;
        default: stall_pattern <= 16'($urandom) | 16'($urandom);
      endcase
      pattern_age <= 15;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_age <= pattern_age - 1;
    end
    token_ch.ready <= rst ? 1'b0 : stall_pattern[0];
  end

  always @(posedge clk) begin : check_tokens
    token_exp_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (awaited_tokens.size() == 0) begin
        $error("token transfer with none expected: kind %0d start %0d length %0d",
               token_ch.token_kind, token_ch.token_start, token_ch.token_length);
        token_errors++;
      end else begin
        want = awaited_tokens.pop_front();
        if (token_ch.token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_ch.token_kind);
          token_errors++;
        end
        if (token_ch.token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, token_ch.token_start);
          token_errors++;
        end
        if (token_ch.token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length,
                 token_ch.token_length);
          token_errors++;
        end
        if (token_ch.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, token_ch.run_end);
          token_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int random_sent;
    bit paused;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.source_byte = 8'h00;
    byte_ch.is_final = 1'b0;
    clear_scan();
    random_sent = 0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_byte(plan[i].ch, plan[i].fin);
      if (plan[i].typed) begin
        repeat (last_count) void'(awaited_tokens.pop_back());
        awaited_tokens.push_back('{plan[i].kind, plan[i].start, plan[i].length, 1'b1});
      end
    end
    drain_tokens();

    while (random_sent < 300) begin
      build_source();
      foreach (source_text[j]) send_byte(source_text[j], j == source_text.size() - 1);
      random_sent += source_text.size();
      if (!paused && random_sent > 150) begin
        drain_tokens();
        paused = 1'b1;
      end
    end
    drain_tokens();

    repeat (8) @(posedge clk);
    if (token_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
